// ===== src/assert_macros.svh =====
// Assertion macros used by record_table_engine_top.
// Each macro expands to a labeled concurrent assertion, or to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

// ===== src/rte_pkg.sv =====
// Package for the record table engine: constants, request codes and payload structs.
// No dependencies.
`default_nettype none
package rte_pkg;
  localparam int Capacity = 16;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int MaxResults = 16;
  localparam int RecW = 192;

  localparam logic [3:0] REQ_ADD = 4'd0;
  localparam logic [3:0] REQ_LIST = 4'd1;
  localparam logic [3:0] REQ_FIND_NAME = 4'd2;
  localparam logic [3:0] REQ_FIND_NUM = 4'd3;
  localparam logic [3:0] REQ_DEL_NAME = 4'd4;
  localparam logic [3:0] REQ_DEL_NUM = 4'd5;
  localparam logic [3:0] REQ_DEL_POS = 4'd6;
  localparam logic [3:0] REQ_RENAME = 4'd7;
  localparam logic [3:0] REQ_RENUM = 4'd8;
  localparam logic [3:0] REQ_SORT_NAME = 4'd9;
  localparam logic [3:0] REQ_SORT_NUM = 4'd10;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [63:0]        key_name_head;
    logic [63:0]        key_name_mid;
    logic [31:0]        key_name_tail;
    logic signed [31:0] key_number;
    logic [63:0]        new_name_head;
    logic [63:0]        new_name_mid;
    logic [31:0]        new_name_tail;
    logic signed [31:0] new_number;
    logic [4:0]         slot_position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_position;
    logic [63:0]        out_name_head;
    logic [63:0]        out_name_mid;
    logic [31:0]        out_name_tail;
    logic signed [31:0] out_number;
    logic [4:0]         record_count;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [63:0] head;
    logic [63:0] mid;
    logic [31:0] tail;
    logic [31:0] num;
  } rec_t;
endpackage
`default_nettype wire

// ===== src/record_table_engine_top.sv =====
// Record table engine: a table of Capacity name/number records in one RAM,
// served by a read-modify-write sequencer. Depends on rte_pkg, rte_ram, assert_macros.svh.
//
// One request is handled at a time. Add and delete-at-position-error finish without a
// table scan. List, find, rename and renumber scan the table with one RAM read per
// record. A found record is held one step behind, so it leaves only when the next one
// is found or the scan ends, and the scan waits only while the output register is full.
// Delete by key and delete at position compact in one pass. A sort runs the i<j
// exchange pattern with one compare per pair, reading both records of each pair
// through the single read port of the record RAM. A new request is taken once the
// last result has entered the output register.
`default_nettype none
`include "assert_macros.svh"
module record_table_engine_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rte_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rte_pkg::rsp_t      out_data
);
  localparam int IW = rte_pkg::IdxW;
  localparam int CW = rte_pkg::CntW;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD, S_EVAL, S_SORT_RDI, S_SORT_RDJ, S_SORT_CMP,
    S_SORT_WRJ, S_DONE
  } state_t;

  state_t        state_r;
  rte_pkg::req_t req_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] i_r, j_r, w_r;
  logic          hit_r;
  logic [4:0]    nres_r;
  rte_pkg::rec_t reci_r, held_r;
  logic          pend_r;
  rte_pkg::rsp_t pend_data_r;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  rte_pkg::rec_t ram_wdata, ram_rdata;

  rte_ram #(.Width(rte_pkg::RecW), .Depth(rte_pkg::Capacity)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  logic key_name_eq, key_num_eq, match, gt;
  assign key_name_eq = ram_rdata.head == req_r.key_name_head &&
                       ram_rdata.mid == req_r.key_name_mid &&
                       ram_rdata.tail == req_r.key_name_tail;
  assign key_num_eq = ram_rdata.num == req_r.key_number;
  always_comb begin
    case (req_r.req_type)
      rte_pkg::REQ_FIND_NAME, rte_pkg::REQ_DEL_NAME, rte_pkg::REQ_RENAME:
        match = key_name_eq;
      default: match = key_num_eq;
    endcase
  end
  always_comb begin
    if (req_r.req_type == rte_pkg::REQ_SORT_NAME) begin
      gt = {reci_r.head, reci_r.mid, reci_r.tail} >
           {ram_rdata.head, ram_rdata.mid, ram_rdata.tail};
    end else begin
      gt = $signed(reci_r.num) > $signed(ram_rdata.num);
    end
  end

  // reporting scans: a new report pushes the held one out
  logic rpt_hit, rpt_room, ev_hold, emit_mid, emit_last;
  rte_pkg::rsp_t emit_data;
  always_comb begin
    rpt_hit = 1'b0;
    if (state_r == S_EVAL) begin
      case (req_r.req_type)
        rte_pkg::REQ_LIST: rpt_hit = 1'b1;
        rte_pkg::REQ_FIND_NAME, rte_pkg::REQ_FIND_NUM,
        rte_pkg::REQ_RENAME, rte_pkg::REQ_RENUM: rpt_hit = match;
        default: rpt_hit = 1'b0;
      endcase
    end
  end
  assign rpt_room = !pend_r || nres_r < 5'(rte_pkg::MaxResults - 1);
  assign ev_hold = rpt_hit && pend_r && rpt_room && !out_free;
  assign emit_mid = rpt_hit && pend_r && rpt_room && out_free;
  assign emit_last = (state_r == S_DONE) && pend_r && out_free;
  always_comb begin
    emit_data = pend_data_r;
    emit_data.last = emit_last;
  end

  function automatic rte_pkg::rsp_t mk(input logic [1:0] st, input logic [CW-1:0] pos,
                                        input rte_pkg::rec_t r, input logic [CW-1:0] cnt);
    rte_pkg::rsp_t o;
    o.status = st;
    o.entry_position = 5'(pos);
    o.out_name_head = r.head;
    o.out_name_mid = r.mid;
    o.out_name_tail = r.tail;
    o.out_number = r.num;
    o.record_count = 5'(cnt);
    o.last = 1'b0;
    return o;
  endfunction

  logic [CW-1:0] pos_ext;
  assign pos_ext = CW'(req_r.slot_position);

  rte_pkg::rec_t edited;
  always_comb begin
    edited = ram_rdata;
    if (req_r.req_type == rte_pkg::REQ_RENAME) begin
      edited.head = req_r.new_name_head;
      edited.mid = req_r.new_name_mid;
      edited.tail = req_r.new_name_tail;
    end else begin
      edited.num = req_r.new_number;
    end
  end

  // RAM port control
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = i_r[IW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = i_r[IW-1:0];
    case (state_r)
      S_DISPATCH: begin
        if (req_r.req_type == rte_pkg::REQ_ADD && count_r < CW'(rte_pkg::Capacity)) begin
          ram_we = 1'b1;
          ram_waddr = count_r[IW-1:0];
          ram_wdata = '{req_r.key_name_head, req_r.key_name_mid,
                        req_r.key_name_tail, req_r.key_number};
        end
      end
      S_EVAL: begin
        case (req_r.req_type)
          rte_pkg::REQ_DEL_NAME, rte_pkg::REQ_DEL_NUM: begin
            ram_we = !match;
            ram_waddr = w_r[IW-1:0];
          end
          rte_pkg::REQ_DEL_POS: begin
            ram_we = (i_r >= pos_ext);
            ram_waddr = w_r[IW-1:0];
          end
          rte_pkg::REQ_RENAME, rte_pkg::REQ_RENUM: begin
            ram_we = match && !ev_hold;
            ram_wdata = edited;
          end
          default: ;
        endcase
      end
      S_SORT_RDJ: ram_raddr = j_r[IW-1:0];
      S_SORT_CMP: begin
        ram_we = gt;
        ram_waddr = i_r[IW-1:0];
        ram_wdata = ram_rdata;
      end
      S_SORT_WRJ: begin
        ram_we = 1'b1;
        ram_waddr = j_r[IW-1:0];
        ram_wdata = held_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_valid <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (emit_mid || emit_last) begin
        out_data <= emit_data;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_data;
            state_r <= S_DISPATCH;
            i_r <= '0;
            w_r <= '0;
            hit_r <= 1'b0;
            nres_r <= '0;
            pend_r <= 1'b0;
          end
        end
        S_DISPATCH: begin
          case (req_r.req_type)
            rte_pkg::REQ_ADD: begin
              if (count_r < CW'(rte_pkg::Capacity)) begin
                count_r <= count_r + 1'b1;
                pend_data_r <= mk(rte_pkg::ST_OK, count_r + 1'b1,
                                  '{req_r.key_name_head, req_r.key_name_mid,
                                    req_r.key_name_tail, req_r.key_number},
                                  count_r + 1'b1);
              end else begin
                pend_data_r <= mk(rte_pkg::ST_FULL, '0, '0, count_r);
              end
              pend_r <= 1'b1;
              state_r <= S_DONE;
            end
            rte_pkg::REQ_LIST, rte_pkg::REQ_FIND_NAME, rte_pkg::REQ_FIND_NUM,
            rte_pkg::REQ_DEL_NAME, rte_pkg::REQ_DEL_NUM,
            rte_pkg::REQ_RENAME, rte_pkg::REQ_RENUM: begin
              state_r <= (count_r == '0) ? S_DONE : S_RD;
            end
            rte_pkg::REQ_DEL_POS: begin
              if (pos_ext == '0 || pos_ext > count_r) begin
                pend_data_r <= mk(rte_pkg::ST_BADPOS, '0, '0, count_r);
                pend_r <= 1'b1;
                state_r <= S_DONE;
              end else begin
                i_r <= pos_ext - 1'b1;
                w_r <= pos_ext - 1'b1;
                state_r <= S_RD;
              end
            end
            rte_pkg::REQ_SORT_NAME, rte_pkg::REQ_SORT_NUM: begin
              state_r <= (count_r < CW'(2)) ? S_DONE : S_SORT_RDI;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_RD: state_r <= S_EVAL;
        S_EVAL: begin
          if (!ev_hold) begin
            case (req_r.req_type)
              rte_pkg::REQ_LIST, rte_pkg::REQ_FIND_NAME, rte_pkg::REQ_FIND_NUM: begin
                if (rpt_hit && rpt_room) begin
                  pend_data_r <= mk(rte_pkg::ST_OK, i_r + 1'b1, ram_rdata, count_r);
                  pend_r <= 1'b1;
                  hit_r <= 1'b1;
                  if (pend_r) begin
                    nres_r <= nres_r + 1'b1;
                  end
                end
              end
              rte_pkg::REQ_RENAME, rte_pkg::REQ_RENUM: begin
                if (rpt_hit && rpt_room) begin
                  pend_data_r <= mk(rte_pkg::ST_OK, i_r + 1'b1, edited, count_r);
                  pend_r <= 1'b1;
                  hit_r <= 1'b1;
                  if (pend_r) begin
                    nres_r <= nres_r + 1'b1;
                  end
                end
              end
              rte_pkg::REQ_DEL_NAME, rte_pkg::REQ_DEL_NUM: begin
                if (match) begin
                  hit_r <= 1'b1;
                end else begin
                  w_r <= w_r + 1'b1;
                end
              end
              rte_pkg::REQ_DEL_POS: begin
                if (i_r + 1'b1 == pos_ext) begin
                  held_r <= ram_rdata;
                end else begin
                  w_r <= w_r + 1'b1;
                end
              end
              default: ;
            endcase
            if (i_r + 1'b1 < count_r) begin
              i_r <= i_r + 1'b1;
              state_r <= S_RD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SORT_RDI: state_r <= S_SORT_RDJ;
        S_SORT_RDJ: begin
          reci_r <= ram_rdata;
          state_r <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (gt) begin
            held_r <= reci_r;
            state_r <= S_SORT_WRJ;
          end else begin
            state_r <= S_SORT_WRJ;
            held_r <= ram_rdata;
          end
        end
        S_SORT_WRJ: begin
          if (j_r + 1'b1 < count_r) begin
            j_r <= j_r + 1'b1;
            state_r <= S_SORT_RDI;
          end else if (i_r + CW'(2) < count_r) begin
            i_r <= i_r + 1'b1;
            j_r <= i_r + CW'(2);
            state_r <= S_SORT_RDI;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!pend_r && !hit_r && (req_r.req_type == rte_pkg::REQ_LIST ||
              req_r.req_type == rte_pkg::REQ_FIND_NAME ||
              req_r.req_type == rte_pkg::REQ_FIND_NUM ||
              req_r.req_type == rte_pkg::REQ_RENAME ||
              req_r.req_type == rte_pkg::REQ_RENUM)) begin
            pend_data_r <= mk(rte_pkg::ST_NONE, '0, '0, count_r);
            pend_r <= 1'b1;
            hit_r <= 1'b1;
          end else if (!pend_r && nres_r == '0 &&
                       (req_r.req_type == rte_pkg::REQ_DEL_NAME ||
                        req_r.req_type == rte_pkg::REQ_DEL_NUM)) begin
            count_r <= w_r;
            pend_data_r <= mk(hit_r ? rte_pkg::ST_OK : rte_pkg::ST_NONE, '0, '0, w_r);
            pend_r <= 1'b1;
            nres_r <= 5'd1;
          end else if (!pend_r && nres_r == '0 && req_r.req_type == rte_pkg::REQ_DEL_POS &&
                       !(pos_ext == '0 || pos_ext > count_r)) begin
            count_r <= count_r - 1'b1;
            pend_data_r <= mk(rte_pkg::ST_OK, pos_ext, held_r, count_r - 1'b1);
            pend_r <= 1'b1;
            nres_r <= 5'd1;
          end else if (!pend_r && nres_r == '0 && !hit_r) begin
            pend_data_r <= mk(rte_pkg::ST_OK, '0, '0, count_r);
            pend_r <= 1'b1;
            nres_r <= 5'd1;
          end else if (pend_r && out_free) begin
            pend_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_SORT_RDI) begin
        if (i_r == '0 && j_r == '0) begin
          j_r <= CW'(1);
        end
      end
      if (state_r == S_DISPATCH) begin
        j_r <= CW'(1);
      end
    end
  end

  `ASSERT_CLK(a_count_bound, clk, rst_n, count_r <= CW'(rte_pkg::Capacity))
  `ASSERT_CLK(a_busy_no_take, clk, rst_n, (state_r != S_IDLE) |-> in_stall)
  `ASSERT_CLK(a_sort_order, clk, rst_n,
              (state_r == S_SORT_RDI) |-> (i_r < j_r && j_r < count_r))
  `ASSERT_CLK(a_out_hold, clk, rst_n,
              (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
  `ASSERT_CLK_NR(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE))
endmodule
`default_nettype wire

// ===== src/rte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rte_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for record_table_engine_top: random and directed table requests with a
// scoreboard that keeps its own copy of the record table. Depends on rte_pkg and the RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] REQ_UNUSED = 4'd15;

  class table_scoreboard;
    rte_pkg::rec_t recs[rte_pkg::Capacity];
    int unsigned count;
    rte_pkg::rsp_t pending[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function rte_pkg::rsp_t make_rsp(logic [1:0] st, int unsigned pos, rte_pkg::rec_t r);
      rte_pkg::rsp_t x;
      x.status = st;
      x.entry_position = pos[4:0];
      x.out_name_head = r.head;
      x.out_name_mid = r.mid;
      x.out_name_tail = r.tail;
      x.out_number = r.num;
      x.record_count = count[4:0];
      x.last = 1'b0;
      return x;
    endfunction

    function bit name_match(rte_pkg::rec_t r, rte_pkg::req_t q);
      return r.head == q.key_name_head && r.mid == q.key_name_mid &&
             r.tail == q.key_name_tail;
    endfunction

    function bit rec_gt(rte_pkg::rec_t a, rte_pkg::rec_t b, bit by_name);
      if (!by_name) return $signed(a.num) > $signed(b.num);
      if (a.head != b.head) return a.head > b.head;
      if (a.mid != b.mid) return a.mid > b.mid;
      return a.tail > b.tail;
    endfunction

    function void note_request(rte_pkg::req_t q);
      rte_pkg::rsp_t res[$];
      rte_pkg::rec_t none;
      rte_pkg::rec_t t;
      int unsigned w;
      bit hit;
      bit m;
      none = '0;
      hit = 0;
      case (q.req_type)
        rte_pkg::REQ_ADD: begin
          if (count >= rte_pkg::Capacity) res.push_back(make_rsp(rte_pkg::ST_FULL, 0, none));
          else begin
            recs[count] = {q.key_name_head, q.key_name_mid, q.key_name_tail, q.key_number};
            count++;
            res.push_back(make_rsp(rte_pkg::ST_OK, count, recs[count - 1]));
          end
        end
        rte_pkg::REQ_LIST: begin
          for (int i = 0; i < count; i++)
            res.push_back(make_rsp(rte_pkg::ST_OK, i + 1, recs[i]));
          if (res.size() == 0) res.push_back(make_rsp(rte_pkg::ST_NONE, 0, none));
        end
        rte_pkg::REQ_FIND_NAME, rte_pkg::REQ_FIND_NUM, rte_pkg::REQ_RENAME,
        rte_pkg::REQ_RENUM: begin
          for (int i = 0; i < count; i++) begin
            m = (q.req_type == rte_pkg::REQ_FIND_NAME || q.req_type == rte_pkg::REQ_RENAME) ?
                name_match(recs[i], q) : recs[i].num == q.key_number;
            if (m) begin
              if (q.req_type == rte_pkg::REQ_RENAME) begin
                recs[i].head = q.new_name_head;
                recs[i].mid = q.new_name_mid;
                recs[i].tail = q.new_name_tail;
              end else if (q.req_type == rte_pkg::REQ_RENUM) begin
                recs[i].num = q.new_number;
              end
              res.push_back(make_rsp(rte_pkg::ST_OK, i + 1, recs[i]));
              hit = 1;
            end
          end
          if (!hit) res.push_back(make_rsp(rte_pkg::ST_NONE, 0, none));
        end
        rte_pkg::REQ_DEL_NAME, rte_pkg::REQ_DEL_NUM: begin
          w = 0;
          for (int i = 0; i < count; i++) begin
            m = (q.req_type == rte_pkg::REQ_DEL_NAME) ? name_match(recs[i], q) :
                recs[i].num == q.key_number;
            if (m) hit = 1;
            else begin
              recs[w] = recs[i];
              w++;
            end
          end
          count = w;
          res.push_back(make_rsp(hit ? rte_pkg::ST_OK : rte_pkg::ST_NONE, 0, none));
        end
        rte_pkg::REQ_DEL_POS: begin
          if (q.slot_position == 0 || q.slot_position > count)
            res.push_back(make_rsp(rte_pkg::ST_BADPOS, 0, none));
          else begin
            t = recs[q.slot_position - 1];
            for (int j = q.slot_position - 1; j + 1 < count; j++) recs[j] = recs[j + 1];
            count--;
            res.push_back(make_rsp(rte_pkg::ST_OK, q.slot_position, t));
          end
        end
        rte_pkg::REQ_SORT_NAME, rte_pkg::REQ_SORT_NUM: begin
          for (int i = 0; i + 1 < count; i++)
            for (int j = i + 1; j < count; j++)
              if (rec_gt(recs[i], recs[j], q.req_type == rte_pkg::REQ_SORT_NAME)) begin
                t = recs[i];
                recs[i] = recs[j];
                recs[j] = t;
              end
          res.push_back(make_rsp(rte_pkg::ST_OK, 0, none));
        end
        default: res.push_back(make_rsp(rte_pkg::ST_OK, 0, none));
      endcase
      res[res.size() - 1].last = 1'b1;
      foreach (res[k]) pending.push_back(res[k]);
    endfunction

    function void check_result(rte_pkg::rsp_t got);
      rte_pkg::rsp_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        $display("%0t: mismatch expected %h actual %h", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  rte_pkg::req_t in_data;
  logic out_valid;
  logic out_stall;
  rte_pkg::rsp_t out_data;
  table_scoreboard sb;
  int idle_cycles;
  int stall_left;
  logic [31:0] name_pool[4];

  record_table_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send(rte_pkg::req_t q);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(q);
  endtask

  function automatic rte_pkg::req_t rand_req();
    rte_pkg::req_t q;
    logic [415:0] bits;
    int k;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    q = bits[$bits(rte_pkg::req_t)-1:0];
    k = $urandom_range(0, 99);
    if (k < 30) q.req_type = rte_pkg::REQ_ADD;
    else if (k < 95) q.req_type = 4'($urandom_range(1, 10));
    else q.req_type = 4'($urandom_range(11, 15));
    if ($urandom_range(0, 3) != 0) begin
      q.key_name_head = {name_pool[$urandom_range(0, 3)], 32'h0};
      q.key_name_mid = '0;
      q.key_name_tail = '0;
      q.key_number = $signed($urandom_range(0, 5)) - 2;
    end
    if ($urandom_range(0, 1)) begin
      q.new_name_head = {name_pool[$urandom_range(0, 3)], 32'h0};
      q.new_name_mid = '0;
      q.new_name_tail = '0;
      q.new_number = $signed($urandom_range(0, 5)) - 2;
    end
    if ($urandom_range(0, 3) != 0) q.slot_position = 5'($urandom_range(0, 17));
    return q;
  endfunction

  function automatic rte_pkg::req_t mk(logic [3:0] rt, logic [63:0] h, logic signed [31:0] n,
                                       logic [4:0] pos);
    rte_pkg::req_t q;
    q = '0;
    q.req_type = rt;
    q.key_name_head = h;
    q.key_number = n;
    q.slot_position = pos;
    return q;
  endfunction

  initial begin
    rte_pkg::req_t q;
    sb = new();
    name_pool[0] = 32'h416E6E00;
    name_pool[1] = 32'h426F6200;
    name_pool[2] = 32'h5A000000;
    name_pool[3] = 32'hFFFFFFFF;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send(mk(rte_pkg::REQ_LIST, '0, '0, '0));
    send(mk(rte_pkg::REQ_SORT_NAME, '0, '0, '0));
    send(mk(rte_pkg::REQ_DEL_POS, '0, '0, 5'd1));
    send(mk(rte_pkg::REQ_FIND_NAME, '0, '0, '0));
    send(mk(rte_pkg::REQ_ADD, '1, 32'sh7FFFFFFF, '0));
    q = mk(rte_pkg::REQ_ADD, '0, 32'sh80000000, '0);
    q.key_name_mid = '1;
    q.key_name_tail = '1;
    send(q);
    for (int i = 0; i < 15; i++)
      send(mk(rte_pkg::REQ_ADD, {name_pool[i % 4], 32'h0}, i % 3, '0));
    send(mk(rte_pkg::REQ_LIST, '0, '0, '0));
    send(mk(rte_pkg::REQ_SORT_NUM, '0, '0, '0));
    send(mk(rte_pkg::REQ_SORT_NAME, '0, '0, '0));
    send(mk(rte_pkg::REQ_DEL_POS, '0, '0, 5'd0));
    send(mk(rte_pkg::REQ_DEL_POS, '0, '0, 5'd16));
    send(mk(rte_pkg::REQ_DEL_POS, '0, '0, 5'd17));
    send(mk(rte_pkg::REQ_RENUM, '0, 32'sd1, '0));
    send(mk(rte_pkg::REQ_DEL_NUM, '0, 32'sd2, '0));
    send(mk(REQ_UNUSED, '0, '0, '0));
    for (int i = 0; i < 150; i++) send(rand_req());
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("== FAIL ==");
      $finish;
    end
  end
endmodule
`default_nettype wire
